// ----- design/lbs_pkg.sv -----
// Shared types, widths and constants for the latency batch statistics block.
package lbs_pkg;

  localparam int DATA_W          = 32;
  localparam int CNT_W           = 16;
  localparam int SUM_W           = 48;
  localparam int EDGE_REGS       = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int OUT_BINS        = 5;
  localparam int STEP_W          = $clog2(SUM_W);
  localparam int MAX_SAMPLES_DEF = 65535;
  localparam int NUM_BINS_DEF    = 5;

  localparam logic [DATA_W-1:0] EDGE_RESET [EDGE_REGS] = '{
    32'd100000, 32'd200000, 32'd300000, 32'd400000
  };

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              is_last;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] min_value;
    logic [DATA_W-1:0] max_value;
    logic [DATA_W-1:0] jitter;
    logic [DATA_W-1:0] mean;
    logic [CNT_W-1:0]  bin_zero;
    logic [CNT_W-1:0]  bin_one;
    logic [CNT_W-1:0]  bin_two;
    logic [CNT_W-1:0]  bin_three;
    logic [CNT_W-1:0]  bin_four;
    logic [CNT_W-1:0]  sample_total;
    logic              overflow;
  } out_t;

  typedef enum logic [1:0] {
    S_ACCUM,
    S_DIVIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- design/lbs_ctrl.sv -----
// Controller state machine: accumulation, mean division and result hand-over.
module lbs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            is_last,
  output logic            in_stall,
  input  lbs_pkg::status_t status,
  output lbs_pkg::cmd_t    cmd
);

  lbs_pkg::state_t state, state_next;
  logic [lbs_pkg::STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::S_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      lbs_pkg::S_ACCUM: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && is_last) begin
          cmd.div_load = 1'b1;
          step_next    = '0;
          state_next   = lbs_pkg::S_DIVIDE;
        end
      end
      lbs_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == lbs_pkg::STEP_W'(lbs_pkg::SUM_W - 1)) begin
          state_next = lbs_pkg::S_FINISH;
        end
      end
      lbs_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = lbs_pkg::S_ACCUM;
        end
      end
      default: begin
        state_next = lbs_pkg::S_ACCUM;
      end
    endcase
  end

endmodule

// ----- design/lbs_dp.sv -----
// Datapath: edge registers, running statistics, bin counters, divider and result register.
module lbs_dp #(
  parameter int MAX_SAMPLES = lbs_pkg::MAX_SAMPLES_DEF,
  parameter int NUM_BINS    = lbs_pkg::NUM_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbs_pkg::in_t                  in_data,
  input  logic                          cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbs_pkg::DATA_W-1:0]    cfg_data,
  input  lbs_pkg::cmd_t                 cmd,
  output lbs_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lbs_pkg::out_t                 out_data
);

  localparam int DW = lbs_pkg::DATA_W;
  localparam int CW = lbs_pkg::CNT_W;
  localparam int SW = lbs_pkg::SUM_W;

  logic [DW-1:0] edge_reg [lbs_pkg::EDGE_REGS];
  logic [DW-1:0] min_seen, max_seen;
  logic [SW-1:0] running_sum, sum_next;
  logic [CW-1:0] sample_counter;
  logic          overflow_flag;
  logic [CW-1:0] bin_cnt [NUM_BINS];
  logic [CW-1:0] bin_out [lbs_pkg::OUT_BINS];
  logic [DW-1:0] s;
  logic          full, update;
  logic [SW-1:0] quot;
  logic [CW:0]   rem, rem_shift;
  logic          ge;

  assign s        = in_data.sample;
  assign full     = sample_counter >= CW'(MAX_SAMPLES);
  assign update   = cmd.accept && !full;
  assign sum_next = full ? running_sum : running_sum + SW'(s);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbs_pkg::EDGE_REGS; i++) begin
        edge_reg[i] <= lbs_pkg::EDGE_RESET[i];
      end
    end else if (cfg_we) begin
      edge_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      min_seen       <= '1;
      max_seen       <= '0;
      running_sum    <= '0;
      sample_counter <= '0;
      overflow_flag  <= 1'b0;
    end else if (cmd.accept) begin
      if (full) begin
        overflow_flag <= 1'b1;
      end else begin
        if (s < min_seen) begin
          min_seen <= s;
        end
        if (s > max_seen) begin
          max_seen <= s;
        end
        running_sum    <= sum_next;
        sample_counter <= sample_counter + 1'b1;
      end
    end
  end

  for (genvar g = 0; g < NUM_BINS; g++) begin : g_bin
    logic [DW-1:0] lo, hi;
    logic          hit;
    if (g == 0) begin : g_lo_zero
      assign lo = '0;
    end else if (g - 1 < lbs_pkg::EDGE_REGS) begin : g_lo_edge
      assign lo = edge_reg[g-1];
    end else begin : g_lo_top
      assign lo = '1;
    end
    if (g == NUM_BINS - 1 || g >= lbs_pkg::EDGE_REGS) begin : g_hi_top
      assign hi = '1;
    end else begin : g_hi_edge
      assign hi = edge_reg[g];
    end
    assign hit = (s >= lo) && (s <= hi);
    always_ff @(posedge clk) begin
      if (rst || cmd.load_out) begin
        bin_cnt[g] <= '0;
      end else if (update && hit && bin_cnt[g] != '1) begin
        bin_cnt[g] <= bin_cnt[g] + 1'b1;
      end
    end
  end

  for (genvar k = 0; k < lbs_pkg::OUT_BINS; k++) begin : g_out_bin
    if (k < NUM_BINS) begin : g_used
      assign bin_out[k] = bin_cnt[k];
    end else begin : g_unused
      assign bin_out[k] = '0;
    end
  end

  // Restoring division of the sum by the count, one quotient bit per cycle.
  assign rem_shift = {rem[CW-1:0], quot[SW-1]};
  assign ge        = rem_shift >= {1'b0, sample_counter};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quot <= sum_next;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[SW-2:0], ge};
      rem  <= ge ? rem_shift - {1'b0, sample_counter} : rem_shift;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.min_value    <= min_seen;
      out_data.max_value    <= max_seen;
      out_data.jitter       <= max_seen - min_seen;
      out_data.mean         <= (sample_counter == '0) ? '0 : quot[DW-1:0];
      out_data.bin_zero     <= bin_out[0];
      out_data.bin_one      <= bin_out[1];
      out_data.bin_two      <= bin_out[2];
      out_data.bin_three    <= bin_out[3];
      out_data.bin_four     <= bin_out[4];
      out_data.sample_total <= sample_counter;
      out_data.overflow     <= overflow_flag;
    end
  end

endmodule

// ----- design/latency_batch_statistics.sv -----
// Top level of the latency batch statistics block.
//
//   Channel  Handshake         Payload
//   in       in_valid/in_stall  in_data (sample, is_last)
//   out      out_valid/out_stall out_data (statistics of one batch)
//   cfg      cfg_we             cfg_index, cfg_data (bin edges)
//
// One sample is taken every cycle while a batch accumulates.
// After the last sample the input stalls through the bit-serial mean division
// and the load of the result, longer while an earlier result waits.
// A result waiting under out_stall does not block the next batch; only the
// next batch's end waits for the result register to drain.
// Reset clears the batch state and restores the edge registers.
module latency_batch_statistics #(
  parameter int MAX_SAMPLES = lbs_pkg::MAX_SAMPLES_DEF,
  parameter int NUM_BINS    = lbs_pkg::NUM_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lbs_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lbs_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbs_pkg::DATA_W-1:0]    cfg_data
);

  lbs_pkg::cmd_t    cmd;
  lbs_pkg::status_t status;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (in_data.is_last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lbs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .NUM_BINS    (NUM_BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/lbs_checker.sv -----
// Port-level checks for the latency batch statistics block, bound to the top level.
module lbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input lbs_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input lbs_pkg::out_t                 out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.is_last |=> in_stall)
    else $error("input not stalled after the last item of a batch");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.sample_total != '0 && out_data.bin_zero <= out_data.sample_total)
    else $error("result item has an impossible sample count");

  a_jitter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.min_value <= out_data.max_value
      && out_data.jitter == out_data.max_value - out_data.min_value)
    else $error("result item has inconsistent minimum, maximum and jitter");

endmodule

bind latency_batch_statistics lbs_checker u_checker (.*);

// ----- bench/lbs_stats_checker.sv -----
// Checker that predicts batch statistics from the sample stream and compares each result.
`timescale 1ns / 1ps

module lbs_stats_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  lbs_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  lbs_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbs_pkg::DATA_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            batches_open
);

  logic [lbs_pkg::DATA_W-1:0] bounds [lbs_pkg::EDGE_REGS];
  logic [lbs_pkg::DATA_W-1:0] lo_mark;
  logic [lbs_pkg::DATA_W-1:0] hi_mark;
  logic [lbs_pkg::SUM_W-1:0]  sum_acc;
  logic [lbs_pkg::CNT_W-1:0]  n_taken;
  logic [lbs_pkg::CNT_W-1:0]  bin_tally [lbs_pkg::OUT_BINS];
  logic                       spilled;
  lbs_pkg::out_t              stats_due [$];
  int                         fault_tally;

  task automatic clear_batch();
    lo_mark = '1;
    hi_mark = '0;
    sum_acc = '0;
    n_taken = '0;
    spilled = 1'b0;
    for (int k = 0; k < lbs_pkg::OUT_BINS; k++) bin_tally[k] = '0;
  endtask

  task automatic absorb(input logic [lbs_pkg::DATA_W-1:0] s, input logic last);
    logic [lbs_pkg::DATA_W-1:0] lo;
    logic [lbs_pkg::DATA_W-1:0] hi;
    logic [lbs_pkg::SUM_W-1:0]  quot;
    lbs_pkg::out_t              stats;
    if (int'(n_taken) >= lbs_pkg::MAX_SAMPLES_DEF) begin
      spilled = 1'b1;
    end else begin
      if (s < lo_mark) lo_mark = s;
      if (s > hi_mark) hi_mark = s;
      sum_acc = sum_acc + lbs_pkg::SUM_W'(s);
      n_taken = n_taken + 1'b1;
      for (int k = 0; k < lbs_pkg::NUM_BINS_DEF; k++) begin
        lo = (k == 0) ? '0 : bounds[k-1];
        hi = (k == lbs_pkg::NUM_BINS_DEF - 1) ? '1 : bounds[k];
        if (s >= lo && s <= hi && bin_tally[k] != '1) bin_tally[k] = bin_tally[k] + 1'b1;
      end
    end
    if (last) begin
      quot = (n_taken != 0) ? sum_acc / lbs_pkg::SUM_W'(n_taken) : '0;
      stats.min_value    = lo_mark;
      stats.max_value    = hi_mark;
      stats.jitter       = hi_mark - lo_mark;
      stats.mean         = quot[lbs_pkg::DATA_W-1:0];
      stats.bin_zero     = bin_tally[0];
      stats.bin_one      = bin_tally[1];
      stats.bin_two      = bin_tally[2];
      stats.bin_three    = bin_tally[3];
      stats.bin_four     = bin_tally[4];
      stats.sample_total = n_taken;
      stats.overflow     = spilled;
      stats_due.push_back(stats);
      clear_batch();
    end
  endtask

  task automatic check_field(input string tag, input logic [lbs_pkg::DATA_W-1:0] want,
                             input logic [lbs_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", tag, want, got);
      fault_tally++;
    end
  endtask

  always @(posedge clk) begin : watch
    lbs_pkg::out_t want;
    if (rst) begin
      for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) bounds[k] = lbs_pkg::EDGE_RESET[k];
      clear_batch();
      stats_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $error("result arrived with no batch outstanding");
          fault_tally++;
        end else begin
          want = stats_due.pop_front();
          check_field("min_value", want.min_value, out_data.min_value);
          check_field("max_value", want.max_value, out_data.max_value);
          check_field("jitter", want.jitter, out_data.jitter);
          check_field("mean", want.mean, out_data.mean);
          check_field("bin_zero", want.bin_zero, out_data.bin_zero);
          check_field("bin_one", want.bin_one, out_data.bin_one);
          check_field("bin_two", want.bin_two, out_data.bin_two);
          check_field("bin_three", want.bin_three, out_data.bin_three);
          check_field("bin_four", want.bin_four, out_data.bin_four);
          check_field("sample_total", want.sample_total, out_data.sample_total);
          check_field("overflow", want.overflow, out_data.overflow);
        end
      end
      if (in_valid && !in_stall) absorb(in_data.sample, in_data.is_last);
      if (cfg_we) bounds[cfg_index] = cfg_data;
    end
    mismatches   <= fault_tally;
    batches_open <= stats_due.size();
  end

endmodule

// ----- bench/tb_latency_batch_statistics.sv -----
// Top of the latency batch statistics testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_latency_batch_statistics;

  typedef enum int {
    SET_SORTED,
    SET_ZERO,
    SET_ONES,
    SET_TANGLED,
    SET_FLAT,
    SET_TINY,
    SET_DEFAULT
  } bound_set_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  lbs_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_stall;
  lbs_pkg::out_t                 out_data;
  logic                          cfg_we;
  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lbs_pkg::DATA_W-1:0]    cfg_data;
  int                            mismatches;
  int                            batches_open;

  logic                          calm;
  logic [lbs_pkg::DATA_W-1:0]    bounds_now [lbs_pkg::EDGE_REGS];
  int                            items_sent;

  latency_batch_statistics i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbs_stats_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .batches_open (batches_open)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 34);
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic [lbs_pkg::DATA_W-1:0] s, input logic last);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {s, last};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (batches_open != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic load_bounds(input logic [lbs_pkg::DATA_W-1:0] b0,
                             input logic [lbs_pkg::DATA_W-1:0] b1,
                             input logic [lbs_pkg::DATA_W-1:0] b2,
                             input logic [lbs_pkg::DATA_W-1:0] b3);
    bounds_now[0] = b0;
    bounds_now[1] = b1;
    bounds_now[2] = b2;
    bounds_now[3] = b3;
    for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= lbs_pkg::CFG_IDX_W'(k);
      cfg_data  <= bounds_now[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [lbs_pkg::DATA_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom();
    if (r < 60) return bounds_now[$urandom_range(lbs_pkg::EDGE_REGS - 1)] + $urandom_range(4) - 2;
    if (r < 70) return ($urandom_range(1) == 1) ? '1 : '0;
    return $urandom_range(500000);
  endfunction

  task automatic send_batch(input int len);
    for (int n = 1; n <= len; n++) send_item(pick_sample(), n == len);
  endtask

  initial begin
    logic [lbs_pkg::DATA_W-1:0] b [lbs_pkg::EDGE_REGS];
    bound_set_t                 set;
    int                         quota;
    rst        = 1'b1;
    calm       = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    items_sent = 0;
    for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) bounds_now[k] = lbs_pkg::EDGE_RESET[k];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item('0, 1'b1);
    send_item('1, 1'b1);
    send_item(32'd100000, 1'b0);
    send_item(32'd200000, 1'b0);
    send_item(32'd300000, 1'b0);
    send_item(32'd400000, 1'b1);
    send_item(32'd99999, 1'b0);
    send_item(32'd100001, 1'b0);
    send_item(32'd399999, 1'b0);
    send_item(32'd400001, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b1);
    send_item('1, 1'b0);
    send_item('1, 1'b0);
    send_item('1, 1'b1);
    send_item(32'd250000, 1'b0);
    send_item(32'd150000, 1'b0);
    send_item(32'd350000, 1'b0);
    send_item(32'd50000, 1'b1);

    for (int p = SET_SORTED; p <= SET_DEFAULT; p++) begin
      set = bound_set_t'(p);
      case (set)
        SET_SORTED: begin
          b[0] = $urandom_range(32'h3FFF_FFFF);
          for (int k = 1; k < lbs_pkg::EDGE_REGS; k++) begin
            b[k] = b[k-1] + $urandom_range(32'h3FFF_FFFF);
          end
        end
        SET_ZERO: begin
          for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) b[k] = '0;
        end
        SET_ONES: begin
          for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) b[k] = '1;
        end
        SET_TANGLED: begin
          for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) b[k] = $urandom();
          b[1] = b[0] - 32'd1000;
        end
        SET_FLAT: begin
          b[0] = $urandom();
          for (int k = 1; k < lbs_pkg::EDGE_REGS; k++) b[k] = b[0];
        end
        SET_TINY: begin
          for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) b[k] = lbs_pkg::DATA_W'(k);
        end
        default: begin
          for (int k = 0; k < lbs_pkg::EDGE_REGS; k++) b[k] = lbs_pkg::EDGE_RESET[k];
        end
      endcase
      drain();
      load_bounds(b[0], b[1], b[2], b[3]);
      calm <= (set == SET_FLAT);
      quota = items_sent + 240;
      while (items_sent < quota) begin
        send_batch(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30));
      end
    end

    send_batch(5);

    drain();
    if (mismatches == 0 && batches_open == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
